[rtl/core/wsd_pkg.sv]
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

  // Width of the payload length register
  localparam int LENGTH_BITS = 64;

  // Configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_MESSAGE_BYTES = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIENT_SIDE       = 8'd1;
  localparam logic [31:0] MAX_MESSAGE_BYTES_RESET = 32'd33554432;  // 32 MiB

  // Frame header codes
  localparam logic [3:0] OP_DATA_LAST = 4'd2;  // opcodes up to this are data
  localparam logic [3:0] OP_PING      = 4'd9;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_EMPTY_END = 3'd1,
    KIND_PONG_REQ  = 3'd2,
    KIND_OVERSIZE  = 3'd3,
    KIND_NO_MASK   = 3'd4
  } kind_t;

endpackage

[rtl/core/wsd_if.sv]
// Channel interfaces of the WebSocket frame deframer.
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] payload_byte;
  logic [3:0] message_type;
  logic       message_last;

  modport source (output valid, output result_kind, output payload_byte,
                  output message_type, output message_last, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input message_type, input message_last, output ready);
endinterface

interface wsd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wsd_pkg::CFG_INDEX_BITS-1:0] index;
  logic [wsd_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/websocket_frame_deframer_unit.sv]
// WebSocket receive-side frame deframer: top level.
//
// Usage:
//   rx  : one received byte per transaction (rx_byte), in stream order.
//   res : at most one result per byte: an unmasked payload byte of a data
//         frame, an empty-message end, a pong request, or an error
//         (oversize / missing mask). Errors halt the block until reset;
//         bytes taken while halted are dropped without a result.
//   cfg : register writes (0 = max_message_bytes, 1 = client_side), always
//         ready; write only while the block is idle. Other indexes ignored.
// Pipeline: a byte taken into the input register is parsed from there, and its
//   result is registered in the result register.
// Throughput: one byte per cycle while res is not stalled; each byte is handled by one pass through
//   the header/length/mask/data logic between the input register and the
//   result register.
// Reset: parser back to "awaiting first header byte", registers to their
//   defaults (32 MiB limit, server role), both pipeline registers empty.
// Stall: while res is stalled the input register still takes one more byte;
//   after that rx.ready drops until the result is taken.
module websocket_frame_deframer_unit (
  input  logic           clk,
  input  logic           rst,
  wsd_rx_if.sink         rx,
  wsd_res_if.source      res,
  wsd_cfg_if.sink        cfg
);
  import wsd_pkg::*;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_advance;

  // Configuration registers
  logic [31:0] max_message_bytes;
  logic        client_side;

  // Parser state
  phase_t                 phase, phase_next;
  logic [LENGTH_BITS-1:0] length_shift, length_shift_next;
  logic [3:0]             len_left, len_left_next;
  logic [31:0]            mask_key, mask_key_next;
  logic                   mask_present, mask_present_next;
  logic [3:0]             frame_type, frame_type_next;
  logic                   frame_final, frame_final_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;
  logic [1:0]             mask_index, mask_index_next;
  logic [32:0]            message_length, message_length_next;
  logic [3:0]             message_opcode, message_opcode_next;
  logic                   halted, halted_next;

  // Working signals
  logic                   is_data;
  logic                   do_after_len;
  logic                   do_after_mask;
  logic                   ping;
  logic [LENGTH_BITS-1:0] len_val;
  logic [LENGTH_BITS-1:0] pl_val;
  logic [LENGTH_BITS-1:0] len_shifted;
  logic [63:0]            len64;
  logic [33:0]            len_sum;
  logic                   oversize;
  logic [1:0]             key_sel;
  logic [7:0]             key_byte;
  logic [7:0]             unmasked;
  logic                   last_byte;
  logic [3:0]             len_left_dec;

  // Result of the current byte
  logic       r_valid;
  kind_t      r_kind;
  logic [7:0] r_byte;
  logic [3:0] r_type;
  logic       r_last;

  assign s1_advance = s1_valid && (!res.valid || res.ready);
  assign rx.ready   = !s1_valid || s1_advance;
  assign cfg.ready  = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= MAX_MESSAGE_BYTES_RESET;
      client_side       <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MAX_MESSAGE_BYTES: max_message_bytes <= cfg.data;
        CFG_CLIENT_SIDE:       client_side       <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign is_data     = (frame_type <= OP_DATA_LAST);
  assign len_shifted = {length_shift[LENGTH_BITS-9:0], s1_byte};
  assign key_sel     = 2'd3 - mask_index;
  assign key_byte    = mask_key[{key_sel, 3'b000} +: 8];
  assign unmasked    = mask_present ? (s1_byte ^ key_byte) : s1_byte;
  assign last_byte   = (payload_left == LENGTH_BITS'(1));
  assign len_left_dec = (len_left != 4'd0) ? (len_left - 4'd1) : len_left;

  // Frame length check against the message limit
  assign len64    = 64'(len_val);
  assign len_sum  = {1'b0, message_length} + {2'b00, len64[31:0]};
  assign oversize = (len64[63:32] != 32'd0) || (len_sum >= {2'b00, max_message_bytes});

  // Parser next state and result
  always_comb begin
    phase_next          = phase;
    length_shift_next   = length_shift;
    len_left_next       = len_left;
    mask_key_next       = mask_key;
    mask_present_next   = mask_present;
    frame_type_next     = frame_type;
    frame_final_next    = frame_final;
    payload_left_next   = payload_left;
    mask_index_next     = mask_index;
    message_length_next = message_length;
    message_opcode_next = message_opcode;
    halted_next         = halted;
    do_after_len        = 1'b0;
    do_after_mask       = 1'b0;
    ping                = 1'b0;
    len_val             = '0;
    pl_val              = payload_left;
    r_valid             = 1'b0;
    r_kind              = KIND_PAYLOAD;
    r_byte              = 8'd0;
    r_type              = 4'd0;
    r_last              = 1'b0;

    if (s1_advance && !halted) begin
      case (phase)
        PH_HDR0: begin
          frame_final_next = s1_byte[7];
          frame_type_next  = s1_byte[3:0];
          phase_next       = PH_HDR1;
        end
        PH_HDR1: begin
          mask_present_next = s1_byte[7];
          if (is_data && !client_side && !s1_byte[7]) begin
            halted_next = 1'b1;
            r_valid     = 1'b1;
            r_kind      = KIND_NO_MASK;
          end else begin
            length_shift_next = '0;
            if (s1_byte[6:0] == LEN7_EXT16 || s1_byte[6:0] == LEN7_EXT64) begin
              len_left_next = (s1_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
              phase_next    = PH_LEN;
            end else begin
              len_left_next     = 4'd0;
              length_shift_next = LENGTH_BITS'(s1_byte[6:0]);
              len_val           = LENGTH_BITS'(s1_byte[6:0]);
              do_after_len      = 1'b1;
            end
            ping = (frame_type == OP_PING);
          end
        end
        PH_LEN: begin
          // 64-bit length with its top bit set, or a length that overflows
          if ((len_left == EXT64_BYTES && s1_byte[7]) ||
              (length_shift[LENGTH_BITS-1 -: 8] != 8'd0)) begin
            halted_next = 1'b1;
            r_valid     = 1'b1;
            r_kind      = KIND_OVERSIZE;
          end else begin
            length_shift_next = len_shifted;
            len_left_next     = len_left_dec;
            if (len_left_dec == 4'd0) begin
              len_val      = len_shifted;
              do_after_len = 1'b1;
            end
          end
        end
        PH_MASK: begin
          mask_key_next   = {mask_key[23:0], s1_byte};
          mask_index_next = mask_index + 2'd1;
          if (mask_index == 2'd3) begin
            do_after_mask = 1'b1;
          end
        end
        PH_DATA: begin
          mask_index_next   = mask_index + 2'd1;
          payload_left_next = payload_left - LENGTH_BITS'(1);
          if (last_byte) begin
            phase_next = PH_HDR0;
          end
          if (is_data) begin
            r_valid = 1'b1;
            r_kind  = KIND_PAYLOAD;
            r_byte  = unmasked;
            r_type  = message_opcode;
            if (last_byte && frame_final) begin
              r_last              = 1'b1;
              message_length_next = '0;
              message_opcode_next = 4'd0;
            end
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end

    // Frame length known: limit check, then mask key or payload
    if (do_after_len) begin
      if (is_data && oversize) begin
        halted_next = 1'b1;
        r_valid     = 1'b1;
        r_kind      = KIND_OVERSIZE;
      end else begin
        if (is_data) begin
          message_length_next = len_sum[32:0];
          if (message_opcode == 4'd0 && frame_type != 4'd0) begin
            message_opcode_next = frame_type;
          end
        end
        payload_left_next = len_val;
        pl_val            = len_val;
        if (mask_present_next) begin
          phase_next      = PH_MASK;
          mask_index_next = 2'd0;
          mask_key_next   = 32'd0;
        end else begin
          do_after_mask = 1'b1;
        end
      end
    end

    // Header complete: payload follows, or an empty frame ends here
    if (do_after_mask) begin
      if (pl_val != '0) begin
        phase_next      = PH_DATA;
        mask_index_next = 2'd0;
      end else begin
        phase_next = PH_HDR0;
        if (is_data && frame_final) begin
          r_valid             = 1'b1;
          r_kind              = KIND_EMPTY_END;
          r_type              = message_opcode_next;
          r_last              = 1'b1;
          message_length_next = '0;
          message_opcode_next = 4'd0;
        end
      end
    end

    // Ping request replaces any other result of its second header byte
    if (ping) begin
      r_valid = 1'b1;
      r_kind  = KIND_PONG_REQ;
      r_byte  = 8'd0;
      r_type  = 4'd0;
      r_last  = 1'b0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      length_shift   <= '0;
      len_left       <= 4'd0;
      mask_key       <= 32'd0;
      mask_present   <= 1'b0;
      frame_type     <= 4'd0;
      frame_final    <= 1'b0;
      payload_left   <= '0;
      mask_index     <= 2'd0;
      message_length <= '0;
      message_opcode <= 4'd0;
      halted         <= 1'b0;
    end else begin
      phase          <= phase_next;
      length_shift   <= length_shift_next;
      len_left       <= len_left_next;
      mask_key       <= mask_key_next;
      mask_present   <= mask_present_next;
      frame_type     <= frame_type_next;
      frame_final    <= frame_final_next;
      payload_left   <= payload_left_next;
      mask_index     <= mask_index_next;
      message_length <= message_length_next;
      message_opcode <= message_opcode_next;
      halted         <= halted_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_advance) begin
      res.valid <= r_valid;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (s1_advance) begin
      res.result_kind  <= r_kind;
      res.payload_byte <= r_byte;
      res.message_type <= r_type;
      res.message_last <= r_last;
    end
  end

`ifndef SYNTHESIS
  // Once halted, only reset brings the parser back
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("deframer left halted state without reset");

  // A byte parsed while halted produces no result
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && halted) |=> !res.valid)
    else $error("result produced while halted");

  // Error results always come with the halt
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.result_kind == KIND_OVERSIZE ||
                   res.result_kind == KIND_NO_MASK)) |-> halted)
    else $error("error result without halt");

  // End-of-message flag only on payload bytes and empty message ends
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.message_last) |->
      (res.result_kind == KIND_PAYLOAD || res.result_kind == KIND_EMPTY_END))
    else $error("message_last on a non-message result");

  // Payload phase always has bytes left to consume
  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (payload_left != '0))
    else $error("payload phase with no bytes left");
`endif

endmodule

[test/tb_top.sv]
// Testbench for the WebSocket frame deframer: directed and random frame streams checked byte by byte.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  // Frame opcodes without a name in the package
  localparam logic [3:0] OPC_CONT       = 4'd0;
  localparam logic [3:0] OPC_TEXT       = 4'd1;
  localparam logic [3:0] OPC_BINARY     = 4'd2;
  localparam logic [3:0] OPC_CLOSE      = 4'd8;
  localparam logic [3:0] OPC_RESERVED_F = 4'hF;

  localparam int LONG_HOLD   = 400;    // receiver hold-off for the backpressure test
  localparam int DRAIN_LIMIT = 20000;  // cycles to wait for outstanding results
  localparam int DRAIN_TAIL  = 8;      // extra cycles waited after the drain loop ends
  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

  typedef enum int {ENC_7, ENC_16, ENC_64} len_enc_t;
  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} rdy_mode_t;
  typedef enum int {FAULT_OVERSIZE, FAULT_NO_MASK, FAULT_BAD_LENGTH} fault_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] pbyte;
    logic [3:0] mtype;
    logic       mlast;
  } deframed_t;

  logic clk = 1'b0;
  logic rst;

  wsd_rx_if  rx ();
  wsd_res_if res ();
  wsd_cfg_if cfg ();

  websocket_frame_deframer_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  always #2 clk = ~clk;

  // Register copies
  logic [31:0] cfg_limit  = MAX_MESSAGE_BYTES_RESET;
  logic        cfg_client = 1'b0;

  // Parser state of the predictor
  phase_t      m_phase     = PH_HDR0;
  logic [63:0] m_len_acc   = '0;
  logic [3:0]  m_len_bytes = '0;
  logic [31:0] m_key       = '0;
  logic        m_masked    = 1'b0;
  logic [3:0]  m_op        = '0;
  logic        m_fin       = 1'b0;
  logic [63:0] m_remaining = '0;
  logic [1:0]  m_key_idx   = '0;
  logic [63:0] m_msg_len   = '0;
  logic [3:0]  m_msg_op    = '0;
  logic        m_halted    = 1'b0;

  deframed_t   deframed_q[$];
  int          mismatches    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned burst_left    = 0;
  int          hold_requests = 0;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_data_frame();
    return m_op <= OP_DATA_LAST;
  endfunction

  task automatic queue_result(input kind_t k, input logic [7:0] pb, input logic [3:0] mt,
                              input logic ml);
    deframed_q.push_back('{k, pb, mt, ml});
  endtask

  task automatic halt_parser(input kind_t k);
    m_halted = 1'b1;
    queue_result(k, '0, '0, 1'b0);
  endtask

  // Header and key done: payload follows, or the frame is over
  task automatic mask_done();
    if (m_remaining != 0) begin
      m_phase   = PH_DATA;
      m_key_idx = '0;
      return;
    end
    m_phase = PH_HDR0;
    if (is_data_frame() && m_fin) begin
      queue_result(KIND_EMPTY_END, '0, m_msg_op, 1'b1);
      m_msg_len = '0;
      m_msg_op  = '0;
    end
  endtask

  // Frame length known: limit check, message bookkeeping
  task automatic length_done();
    if (is_data_frame()) begin
      if (m_len_acc >= 64'(cfg_limit) || m_msg_len + m_len_acc >= 64'(cfg_limit)) begin
        halt_parser(KIND_OVERSIZE);
        return;
      end
      m_msg_len += m_len_acc;
      if (m_msg_op == 0 && m_op != OPC_CONT) m_msg_op = m_op;
    end
    m_remaining = m_len_acc;
    if (m_masked) begin
      m_phase   = PH_MASK;
      m_key_idx = '0;
      m_key     = '0;
    end else begin
      mask_done();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] plain;
    if (m_halted) return;
    case (m_phase)
      PH_HDR0: begin
        m_fin   = b[7];
        m_op    = b[3:0];
        m_phase = PH_HDR1;
      end
      PH_HDR1: begin
        m_masked = b[7];
        if (is_data_frame() && !cfg_client && !b[7]) begin
          halt_parser(KIND_NO_MASK);
          return;
        end
        m_len_acc = '0;
        if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
          m_len_bytes = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          m_phase     = PH_LEN;
        end else begin
          m_len_bytes = '0;
          m_len_acc   = 64'(b[6:0]);
          length_done();
        end
        if (m_op == OP_PING) queue_result(KIND_PONG_REQ, '0, '0, 1'b0);
      end
      PH_LEN: begin
        // top bit of a 64-bit length, or a length too wide for the register
        if (m_len_bytes == EXT64_BYTES && b[7]) begin
          halt_parser(KIND_OVERSIZE);
          return;
        end
        if ((m_len_acc >> (LENGTH_BITS - 8)) != 0) begin
          halt_parser(KIND_OVERSIZE);
          return;
        end
        m_len_acc = ((m_len_acc << 8) | 64'(b)) & LEN_MASK;
        if (m_len_bytes != 0) m_len_bytes--;
        if (m_len_bytes == 0) length_done();
      end
      PH_MASK: begin
        m_key = {m_key[23:0], b};
        m_key_idx++;
        if (m_key_idx == 0) mask_done();
      end
      PH_DATA: begin
        plain = m_masked ? (b ^ m_key[(3 - m_key_idx) * 8 +: 8]) : b;
        m_key_idx++;
        m_remaining--;
        if (m_remaining == 0) m_phase = PH_HDR0;
        if (!is_data_frame()) return;
        if (m_remaining == 0 && m_fin) begin
          queue_result(KIND_PAYLOAD, plain, m_msg_op, 1'b1);
          m_msg_len = '0;
          m_msg_op  = '0;
        end else begin
          queue_result(KIND_PAYLOAD, plain, m_msg_op, 1'b0);
        end
      end
      default: m_phase = PH_HDR0;
    endcase
  endtask

  // ---------------------------------------------------------------- drivers

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic len_enc_t pick_enc(input int unsigned len);
    if (len < 126) return len_enc_t'($urandom_range(0, 2));
    return ($urandom_range(0, 1) != 0) ? ENC_16 : ENC_64;
  endfunction

  // One rx transaction; the sender sometimes idles between bursts of random length
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        rx.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_frame(input logic [3:0] op, input logic fin, input logic masked,
                            input int unsigned len, input len_enc_t enc,
                            input logic [31:0] key, input logic [2:0] rsv);
    logic [63:0] len64;
    len64 = 64'(len);
    push_byte({fin, rsv, op});
    case (enc)
      ENC_7: push_byte({masked, len64[6:0]});
      ENC_16: begin
        push_byte({masked, LEN7_EXT16});
        push_byte(len64[15:8]);
        push_byte(len64[7:0]);
      end
      default: begin
        push_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len64[i * 8 +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) push_byte(key[i * 8 +: 8]);
    for (int unsigned i = 0; i < len; i++) push_byte(pick_byte());
  endtask

  // Stop sending and wait until every expected result has come out or the wait limit runs out
  task automatic quiesce();
    int waited;
    @(negedge clk);
    rx.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (deframed_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == CFG_MAX_MESSAGE_BYTES) cfg_limit = val;
    else if (idx == CFG_CLIENT_SIDE) cfg_client = val[0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Close any open message so a lower limit cannot trip it, drain, then write both registers
  task automatic configure(input logic [31:0] limit, input logic client);
    send_frame(OPC_CONT, 1'b1, !cfg_client || ($urandom_range(0, 1) != 0), 0, ENC_7,
               $urandom, 3'($urandom));
    quiesce();
    write_reg(CFG_MAX_MESSAGE_BYTES, limit);
    write_reg(CFG_CLIENT_SIDE, 32'(client));
  endtask

  // Well-formed frame with random content that stays under the message limit
  task automatic send_random_frame();
    logic [3:0]      op;
    logic            fin;
    logic            masked;
    longint unsigned room;
    int unsigned     cap;
    int unsigned     len;
    int unsigned     pick;
    logic [31:0]     key;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      op = 4'($urandom_range(0, 2));
    end else if (pick < 85) begin
      op = 4'(8 + $urandom_range(0, 2));
    end else begin
      op = 4'($urandom_range(3, 12));
      if (op >= OPC_CLOSE) op = op + 4'd3;
    end
    cap = ($urandom_range(0, 19) == 0) ? 300 : 24;
    if (op <= OP_DATA_LAST) begin
      masked = !cfg_client || ($urandom_range(0, 1) != 0);
      fin    = ($urandom_range(0, 2) != 0);
      room   = 64'(cfg_limit) - m_msg_len - 1;
      len    = (room < cap) ? int'(room) : cap;
      // mostly random, sometimes right at the limit
      if ($urandom_range(0, 7) != 0) len = $urandom_range(0, len);
    end else begin
      masked = ($urandom_range(0, 1) != 0);
      fin    = ($urandom_range(0, 1) != 0);
      len    = $urandom_range(0, cap);
    end
    key = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
    send_frame(op, fin, masked, len, pick_enc(len), key, 3'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // Reset register values: masked text, unmasked ping, empty binary end
  task automatic test_header_forms();
    send_frame(OPC_TEXT, 1'b1, 1'b1, 2, ENC_7, 32'hFFFF_FFFF, 3'b000);
    send_frame(OP_PING, 1'b1, 1'b0, 0, ENC_7, 32'h0, 3'b000);
    send_frame(OPC_BINARY, 1'b1, 1'b1, 0, ENC_7, 32'h1234_5678, 3'b000);
  endtask

  // Client role: extended lengths, continuation-first message, skipped frames
  task automatic test_length_forms();
    configure(32'hFFFF_FFFF, 1'b1);
    send_frame(OPC_BINARY, 1'b1, 1'b0, 1, ENC_16, 32'h0, 3'b101);
    send_frame(OPC_CONT, 1'b0, 1'b0, 1, ENC_64, 32'h0, 3'b000);
    send_frame(OPC_TEXT, 1'b1, 1'b0, 0, ENC_7, 32'h0, 3'b010);
    send_frame(OPC_CLOSE, 1'b1, 1'b0, 0, ENC_7, 32'h0, 3'b000);
    send_frame(OPC_RESERVED_F, 1'b1, 1'b1, 1, ENC_7, 32'h0, 3'b111);
  endtask

  task automatic test_random_traffic(input int unsigned n, input logic [31:0] limit,
                                     input logic client);
    int unsigned start;
    configure(limit, client);
    start = bytes_sent;
    while (bytes_sent - start < n) send_random_frame();
  endtask

  // Receiver holds off while a long frame keeps coming, so rx must stall
  task automatic test_backpressure();
    configure(32'hFFFF_FFFF, 1'b1);
    @(posedge clk);
    hold_requests++;
    send_frame(OPC_BINARY, 1'b1, 1'b1, 160, ENC_16, $urandom, 3'b000);
  endtask

  // One halting error per run; later bytes must be dropped
  task automatic test_fatal_error();
    fault_t     which;
    logic [3:0] op;
    which = fault_t'($urandom_range(0, 2));
    case (which)
      FAULT_OVERSIZE: begin
        configure(32'd10, cfg_client);
        send_frame(OPC_TEXT, 1'b0, 1'b1, 4, ENC_7, $urandom, 3'b000);
        send_frame(OPC_CONT, 1'b1, 1'b1, 6, pick_enc(6), $urandom, 3'b000);
      end
      FAULT_NO_MASK: begin
        configure(cfg_limit, 1'b0);
        send_frame(OPC_BINARY, 1'b1, 1'b0, 3, ENC_7, 32'h0, 3'b000);
      end
      default: begin
        op = 4'($urandom);
        push_byte({1'b1, 3'($urandom), op});
        push_byte({1'b1, LEN7_EXT64});
        push_byte(8'h80 | 8'($urandom));
      end
    endcase
    repeat (8) push_byte(pick_byte());
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall pattern is picked anew after each random span; long hold-off on request
  initial begin : res_ready_gen
    rdy_mode_t mode;
    int        span;
    int        hold_left;
    int        hold_granted;
    res.ready    = 1'b0;
    mode         = RDY_ALWAYS;
    span         = 0;
    hold_left    = 0;
    hold_granted = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_granted) begin
        hold_granted = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = rdy_mode_t'($urandom_range(0, 3));
          span = $urandom_range(8, 64);
        end
        span--;
        case (mode)
          RDY_ALWAYS: res.ready <= 1'b1;
          RDY_COIN:   res.ready <= 1'($urandom);
          RDY_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
          default:    res.ready <= ~res.ready;
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    deframed_t want;
    if (!rst && res.valid && res.ready) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %0h type %0d last %0b", $time,
                 res.result_kind, res.payload_byte, res.message_type, res.message_last);
        mismatches++;
      end else begin
        want = deframed_q.pop_front();
        if (res.result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                   res.result_kind);
          mismatches++;
        end
        if (res.payload_byte !== want.pbyte) begin
          $display("%0t: payload_byte expected %0h actual %0h", $time, want.pbyte,
                   res.payload_byte);
          mismatches++;
        end
        if (res.message_type !== want.mtype) begin
          $display("%0t: message_type expected %0d actual %0d", $time, want.mtype,
                   res.message_type);
          mismatches++;
        end
        if (res.message_last !== want.mlast) begin
          $display("%0t: message_last expected %0b actual %0b", $time, want.mlast,
                   res.message_last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_tests
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    cfg.valid  = 1'b0;
    cfg.index  = '0;
    cfg.data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_header_forms();
    test_length_forms();
    test_random_traffic(600, 32'hFFFF_FFFF, 1'b1);
    test_backpressure();
    test_random_traffic(500, MAX_MESSAGE_BYTES_RESET, 1'b0);
    test_random_traffic(250, 32'd1, 1'b0);
    test_random_traffic(400, 32'd37, 1'b1);
    test_random_traffic(300, 32'hFFFF_FFFF, 1'b0);
    test_fatal_error();
    quiesce();

    if (deframed_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, deframed_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
